FILE: rtl/vmbr_pkg.sv
// Package: types and constants shared by the virtio-MMIO block register file.
package vmbr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_POLL  = 2'd2,
        CMD_ID    = 2'd3
    } t_command;

    localparam logic [11:0] OFS_MAGIC         = 12'h000;
    localparam logic [11:0] OFS_VERSION       = 12'h004;
    localparam logic [11:0] OFS_DEVICE_ID     = 12'h008;
    localparam logic [11:0] OFS_VENDOR_ID     = 12'h00C;
    localparam logic [11:0] OFS_DEV_FEATURES  = 12'h010;
    localparam logic [11:0] OFS_DRV_FEATURES  = 12'h020;
    localparam logic [11:0] OFS_PAGE_SIZE     = 12'h028;
    localparam logic [11:0] OFS_QUEUE_SEL     = 12'h030;
    localparam logic [11:0] OFS_QUEUE_NUM_MAX = 12'h034;
    localparam logic [11:0] OFS_QUEUE_NUM     = 12'h038;
    localparam logic [11:0] OFS_QUEUE_PFN     = 12'h040;
    localparam logic [11:0] OFS_QUEUE_NOTIFY  = 12'h050;
    localparam logic [11:0] OFS_STATUS        = 12'h070;

    localparam logic [31:0] MAGIC_VALUE     = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE   = 32'h0000_0001;
    localparam logic [31:0] DEVICE_ID_VALUE = 32'h0000_0002;
    localparam logic [31:0] VENDOR_ID_VALUE = 32'h554D_4551;
    localparam logic [31:0] QUEUE_MAX_VALUE = 32'd8;
    localparam logic [6:0]  ACCESS_BITS     = 7'd32;

    typedef struct packed {
        t_command    command;
        logic [11:0] address;
        logic [6:0]  access_bits;
        logic [31:0] write_value;
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fault;
        logic        interrupt;
        logic [63:0] descriptor_address;
        logic [15:0] request_id;
    } t_rsp;

endpackage

FILE: rtl/vmbr_if.sv
// Interfaces: command channel and result channel with valid/ready handshake.
interface vmbr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [6:0]  access_bits;
    logic [31:0] write_value;

    modport source (output valid, command, address, access_bits, write_value, input ready);
    modport sink   (input valid, command, address, access_bits, write_value, output ready);
endinterface

interface vmbr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        fault;
    logic        interrupt;
    logic [63:0] descriptor_address;
    logic [15:0] request_id;

    modport source (output valid, read_data, fault, interrupt, descriptor_address,
                    request_id, input ready);
    modport sink   (input valid, read_data, fault, interrupt, descriptor_address,
                    request_id, output ready);
endinterface

FILE: rtl/vmbr_in_reg.sv
// Input register: holds one accepted command transaction until it is processed.
module vmbr_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vmbr_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_advance,
    output vmbr_pkg::t_cmd o_cmd
);
    logic           r_valid;
    vmbr_pkg::t_cmd r_cmd;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end
endmodule

FILE: rtl/vmbr_core.sv
// Register state, command decode, read mux and descriptor address product.
module vmbr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  vmbr_pkg::t_cmd i_cmd,
    output vmbr_pkg::t_rsp o_rsp
);
    logic [31:0] r_drv_features, n_drv_features;
    logic [31:0] r_page_bytes,   n_page_bytes;
    logic [31:0] r_queue_index,  n_queue_index;
    logic [31:0] r_queue_num,    n_queue_num;
    logic [31:0] r_queue_pfn,    n_queue_pfn;
    logic        r_notify_pend,  n_notify_pend;
    logic [31:0] r_notify_queue, n_notify_queue;
    logic [31:0] r_status,       n_status;
    logic [15:0] r_last_id,      n_last_id;
    logic        w_word;
    logic [31:0] w_rdata;
    logic [63:0] w_prod;

    assign w_word = (i_cmd.access_bits == vmbr_pkg::ACCESS_BITS);

    always_comb begin
        case (i_cmd.address)
            vmbr_pkg::OFS_MAGIC:         w_rdata = vmbr_pkg::MAGIC_VALUE;
            vmbr_pkg::OFS_VERSION:       w_rdata = vmbr_pkg::VERSION_VALUE;
            vmbr_pkg::OFS_DEVICE_ID:     w_rdata = vmbr_pkg::DEVICE_ID_VALUE;
            vmbr_pkg::OFS_VENDOR_ID:     w_rdata = vmbr_pkg::VENDOR_ID_VALUE;
            vmbr_pkg::OFS_DRV_FEATURES:  w_rdata = r_drv_features;
            vmbr_pkg::OFS_QUEUE_NUM_MAX: w_rdata = vmbr_pkg::QUEUE_MAX_VALUE;
            vmbr_pkg::OFS_QUEUE_PFN:     w_rdata = r_queue_pfn;
            vmbr_pkg::OFS_STATUS:        w_rdata = r_status;
            default:                     w_rdata = '0;
        endcase
    end

    always_comb begin
        n_drv_features = r_drv_features;
        n_page_bytes   = r_page_bytes;
        n_queue_index  = r_queue_index;
        n_queue_num    = r_queue_num;
        n_queue_pfn    = r_queue_pfn;
        n_notify_pend  = r_notify_pend;
        n_notify_queue = r_notify_queue;
        n_status       = r_status;
        n_last_id      = r_last_id;
        o_rsp          = '0;
        case (i_cmd.command)
            vmbr_pkg::CMD_LOAD: begin
                if (w_word) o_rsp.read_data = w_rdata;
                else        o_rsp.fault     = 1'b1;
            end
            vmbr_pkg::CMD_STORE: begin
                if (w_word) begin
                    case (i_cmd.address)
                        vmbr_pkg::OFS_DRV_FEATURES: n_drv_features = i_cmd.write_value;
                        vmbr_pkg::OFS_PAGE_SIZE:    n_page_bytes   = i_cmd.write_value;
                        vmbr_pkg::OFS_QUEUE_SEL:    n_queue_index  = i_cmd.write_value;
                        vmbr_pkg::OFS_QUEUE_NUM:    n_queue_num    = i_cmd.write_value;
                        vmbr_pkg::OFS_QUEUE_PFN:    n_queue_pfn    = i_cmd.write_value;
                        vmbr_pkg::OFS_QUEUE_NOTIFY: begin
                            n_notify_queue = i_cmd.write_value;
                            n_notify_pend  = 1'b1;
                        end
                        vmbr_pkg::OFS_STATUS:       n_status       = i_cmd.write_value;
                        default: ;
                    endcase
                end else begin
                    o_rsp.fault = 1'b1;
                end
            end
            vmbr_pkg::CMD_POLL: begin
                if (r_notify_pend) begin
                    n_notify_pend   = 1'b0;
                    n_notify_queue  = '1;
                    o_rsp.interrupt = 1'b1;
                end
            end
            vmbr_pkg::CMD_ID: begin
                n_last_id        = r_last_id + 16'd1;
                o_rsp.request_id = n_last_id;
            end
            default: ;
        endcase
        o_rsp.descriptor_address = w_prod;
    end

    // descriptor address reflects this transaction's update
    assign w_prod = n_queue_pfn * n_page_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv_features <= '0;
            r_page_bytes   <= '0;
            r_queue_index  <= '0;
            r_queue_num    <= '0;
            r_queue_pfn    <= '0;
            r_notify_pend  <= 1'b0;
            r_notify_queue <= '1;
            r_status       <= '0;
            r_last_id      <= '0;
        end else if (i_fire) begin
            r_drv_features <= n_drv_features;
            r_page_bytes   <= n_page_bytes;
            r_queue_index  <= n_queue_index;
            r_queue_num    <= n_queue_num;
            r_queue_pfn    <= n_queue_pfn;
            r_notify_pend  <= n_notify_pend;
            r_notify_queue <= n_notify_queue;
            r_status       <= n_status;
            r_last_id      <= n_last_id;
        end
    end

    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.command == vmbr_pkg::CMD_POLL && r_notify_pend)
        |=> (!r_notify_pend && r_notify_queue == 32'hFFFF_FFFF))
        else $error("poll did not clear pending notify");

    a_id_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.command == vmbr_pkg::CMD_ID)
        |=> (r_last_id == $past(o_rsp.request_id)))
        else $error("id counter out of step with returned id");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_rsp.fault)
        |=> ($stable(r_queue_pfn) && $stable(r_page_bytes) && $stable(r_status)
             && $stable(r_notify_pend) && $stable(r_drv_features)))
        else $error("faulting access changed state");

    a_fault_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_rsp.fault) |-> (o_rsp.read_data == 32'd0 && !o_rsp.interrupt))
        else $error("faulting access returned data");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_last_id) && $stable(r_queue_index) && $stable(r_queue_num)))
        else $error("state changed without a transaction");
endmodule

FILE: rtl/vmbr_out_reg.sv
// Output register: holds one result transaction until the sink takes it.
module vmbr_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vmbr_pkg::t_rsp i_rsp,
    output logic           o_valid,
    input  logic           i_ready,
    output vmbr_pkg::t_rsp o_rsp
);
    logic           r_valid;
    vmbr_pkg::t_rsp r_rsp;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rsp <= i_rsp;
        end
    end
endmodule

FILE: rtl/virtio_mmio_block_registers.sv
// Top level: legacy virtio-MMIO block device register file.
//
//   channel  dir  payload
//   i_cmd    in   command, address, access_bits, write_value
//   o_rsp    out  read_data, fault, interrupt, descriptor_address, request_id
//
// One transaction per cycle sustained while o_rsp is not stalled; a result passes
// through the input register, then decode/update/32x32 product into the output register.
// Reset is synchronous on i_rst_n; both pipeline stages empty, registers to defaults.
// A stall on o_rsp holds the output register; the input register keeps accepting
// until it too is full, then i_cmd.ready drops.
module virtio_mmio_block_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vmbr_cmd_if.sink    i_cmd,
    vmbr_rsp_if.source  o_rsp
);
    vmbr_pkg::t_cmd w_cmd_in;
    vmbr_pkg::t_cmd w_cmd_q;
    vmbr_pkg::t_rsp w_rsp;
    vmbr_pkg::t_rsp w_rsp_q;
    logic           w_cmd_valid;
    logic           w_out_ready;
    logic           w_fire;

    assign w_cmd_in.command     = vmbr_pkg::t_command'(i_cmd.command);
    assign w_cmd_in.address     = i_cmd.address;
    assign w_cmd_in.access_bits = i_cmd.access_bits;
    assign w_cmd_in.write_value = i_cmd.write_value;

    assign w_fire = w_cmd_valid && w_out_ready;

    vmbr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .o_ready   (i_cmd.ready),
        .i_cmd     (w_cmd_in),
        .o_valid   (w_cmd_valid),
        .i_advance (w_out_ready),
        .o_cmd     (w_cmd_q)
    );

    vmbr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (w_cmd_q),
        .o_rsp   (w_rsp)
    );

    vmbr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmd_valid),
        .o_ready (w_out_ready),
        .i_rsp   (w_rsp),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_rsp   (w_rsp_q)
    );

    assign o_rsp.read_data          = w_rsp_q.read_data;
    assign o_rsp.fault              = w_rsp_q.fault;
    assign o_rsp.interrupt          = w_rsp_q.interrupt;
    assign o_rsp.descriptor_address = w_rsp_q.descriptor_address;
    assign o_rsp.request_id         = w_rsp_q.request_id;
endmodule
